// ===== hdl/spl_pkg.sv =====
package spl_pkg;

    // Table depth and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 5) ? CNT_W : 5;

    // Operation codes.
    localparam logic [2:0] FN_INSERT     = 3'd0;
    localparam logic [2:0] FN_REM_FIRST  = 3'd1;
    localparam logic [2:0] FN_REM_LAST   = 3'd2;
    localparam logic [2:0] FN_REM_ID     = 3'd3;
    localparam logic [2:0] FN_READ_NTH   = 3'd4;
    localparam logic [2:0] FN_PEEK_FIRST = 3'd5;
    localparam logic [2:0] FN_PEEK_LAST  = 3'd6;
    localparam logic [2:0] FN_EXISTS     = 3'd7;

    // Status codes.
    localparam logic [2:0] STS_OK    = 3'd0;
    localparam logic [2:0] STS_EMPTY = 3'd1;
    localparam logic [2:0] STS_NOID  = 3'd2;
    localparam logic [2:0] STS_FULL  = 3'd3;
    localparam logic [2:0] STS_RANGE = 3'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_INSERT,
        SEQ_SCAN,
        SEQ_DROP
    } seq_state_t;

endpackage

// ===== hdl/sorted_priority_list.sv =====
// Sorted priority table of up to CAPACITY entries (age key, id), kept in
// ascending age order; a new entry goes in front of entries of equal age.
// An item (func, dog_age, dog_id, position) is taken at a rising edge where
// start is high and busy is low. Its single result appears on status,
// out_age, out_id, found and entry_count for exactly one cycle with done
// high; the receiver cannot stall, so the result must be taken then.
// The table has one read port and one write port, so the sequencer reads
// and writes one entry per cycle. Peek, read nth, remove last, an empty
// table, a full table and a position out of range are answered from idle,
// and busy never rises. Insert walks back from the tail, moving up each
// entry with age at or above the new age; remove first moves every later
// entry down one place; exists scans ids from the front until a match or
// the end; remove id scans the same way and closes the gap if it finds one.
// busy is high while the sequencer walks the table and falls as done rises,
// so the next item can be taken at the edge that takes the result. The
// entry_count output shows the count after the operation during the done
// cycle. Reset clears the count and the sequencer; the entry storage itself
// is not cleared, and no entry beyond the count is used in a result.
module sorted_priority_list
    import spl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [7:0]  dog_age,
    input  logic [15:0] dog_id,
    input  logic [4:0]  position,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  out_age,
    output logic [15:0] out_id,
    output logic        found,
    output logic [4:0]  entry_count
);

    // Entry storage.
    logic [7:0]  age_mem [CAPACITY];
    logic [15:0] id_mem  [CAPACITY];

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [2:0]       op_reg, op_next;
    logic [7:0]       key_age_reg, key_age_next;
    logic [15:0]      key_id_reg, key_id_next;
    logic             done_reg, done_next;
    logic [2:0]       status_reg, status_next;
    logic [7:0]       out_age_reg, out_age_next;
    logic [15:0]      out_id_reg, out_id_next;
    logic             found_reg, found_next;

    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_age;
    logic [15:0]      rd_id;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_age;
    logic [15:0]      wr_id;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CNT_W-1:0] idx_inc;

    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);
    assign idx_inc = idx_reg + 1'b1;

    // Single read port.
    assign rd_age = age_mem[rd_addr];
    assign rd_id  = id_mem[rd_addr];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            age_mem[wr_addr] <= wr_age;
            id_mem[wr_addr]  <= wr_id;
        end
    end

    // Read address follows the active step of the sequencer.
    always_comb
    begin
        rd_addr = '0;
        unique case (state_reg)
            SEQ_INSERT: rd_addr = IDX_W'(idx_reg - 1'b1);
            SEQ_SCAN:   rd_addr = IDX_W'(idx_reg);
            SEQ_DROP:   rd_addr = IDX_W'(idx_inc);
            SEQ_IDLE:
            begin
                unique case (func)
                    FN_REM_LAST,
                    FN_PEEK_LAST: rd_addr = IDX_W'(count_reg - 1'b1);
                    FN_READ_NTH:  rd_addr = IDX_W'(position - 1'b1);
                    default:      rd_addr = '0;
                endcase
            end
            default:    rd_addr = '0;
        endcase
    end

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        op_reg      <= op_next;
        key_age_reg <= key_age_next;
        key_id_reg  <= key_id_next;
        status_reg  <= status_next;
        out_age_reg <= out_age_next;
        out_id_reg  <= out_id_next;
        found_reg   <= found_next;
    end

    // Sequencer: next state, table updates and result.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        key_age_next = key_age_reg;
        key_id_next  = key_id_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        out_age_next = out_age_reg;
        out_id_next  = out_id_reg;
        found_next   = found_reg;
        wr_en        = 1'b0;
        wr_addr      = IDX_W'(idx_reg);
        wr_age       = rd_age;
        wr_id        = rd_id;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    op_next      = func;
                    key_age_next = dog_age;
                    key_id_next  = dog_id;
                    status_next  = STS_OK;
                    out_age_next = '0;
                    out_id_next  = '0;
                    found_next   = 1'b0;
                    idx_next     = '0;
                    if (func == FN_INSERT)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = STS_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = SEQ_INSERT;
                        end
                    end
                    else if (func == FN_EXISTS)
                    begin
                        if (count_reg == '0)
                            done_next = 1'b1;
                        else
                            state_next = SEQ_SCAN;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = STS_EMPTY;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        unique case (func)
                            FN_REM_FIRST:
                            begin
                                out_age_next = rd_age;
                                out_id_next  = rd_id;
                                state_next   = SEQ_DROP;
                            end
                            FN_REM_LAST:
                            begin
                                out_age_next = rd_age;
                                out_id_next  = rd_id;
                                count_next   = count_reg - 1'b1;
                                done_next    = 1'b1;
                            end
                            FN_REM_ID:
                            begin
                                state_next = SEQ_SCAN;
                            end
                            FN_READ_NTH:
                            begin
                                if (pos_ext == '0 || pos_ext > cnt_ext)
                                begin
                                    status_next = STS_RANGE;
                                end
                                else
                                begin
                                    out_age_next = rd_age;
                                    out_id_next  = rd_id;
                                end
                                done_next = 1'b1;
                            end
                            default:
                            begin
                                // Peek first or last.
                                out_age_next = rd_age;
                                out_id_next  = rd_id;
                                done_next    = 1'b1;
                            end
                        endcase
                    end
                end
            end

            SEQ_INSERT:
            begin
                // Walk back from the tail, moving up entries not below the new age.
                wr_en = 1'b1;
                if (idx_reg != '0 && rd_age >= key_age_reg)
                begin
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    wr_age     = key_age_reg;
                    wr_id      = key_id_reg;
                    count_next = count_reg + 1'b1;
                    done_next  = 1'b1;
                    state_next = SEQ_IDLE;
                end
            end

            SEQ_SCAN:
            begin
                // One id compare per cycle from the front.
                if (idx_reg == count_reg)
                begin
                    if (op_reg == FN_REM_ID)
                        status_next = STS_NOID;
                    done_next  = 1'b1;
                    state_next = SEQ_IDLE;
                end
                else if (rd_id == key_id_reg)
                begin
                    out_age_next = rd_age;
                    out_id_next  = rd_id;
                    found_next   = 1'b1;
                    if (op_reg == FN_REM_ID)
                    begin
                        state_next = SEQ_DROP;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = SEQ_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            SEQ_DROP:
            begin
                // Close the gap by moving later entries down one place.
                if (idx_inc < count_reg)
                begin
                    wr_en    = 1'b1;
                    idx_next = idx_inc;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    done_next  = 1'b1;
                    state_next = SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != SEQ_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign out_age     = out_age_reg;
    assign out_id      = out_id_reg;
    assign found       = found_reg;
    assign entry_count = 5'(count_reg);

endmodule
